// ----- hw/rtl/touch_swipe_tap_classifier_unit_macros.svh -----
// Assertion macros shared by the touch stroke classifier RTL.
`ifndef TOUCH_SWIPE_TAP_CLASSIFIER_UNIT_MACROS_SVH
`define TOUCH_SWIPE_TAP_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tstc_pkg.sv -----
// Types and constants of the touch stroke classifier.
package tstc_pkg;

   // Event kinds carried in the request word.
   typedef enum logic [1:0] {
      REQ_X_SAMPLE  = 2'd0,
      REQ_Y_SAMPLE  = 2'd1,
      REQ_BUTTON    = 2'd2,
      REQ_TICK      = 2'd3
   } req_kind_type;

   // Gesture codes carried in the response word.
   typedef enum logic [2:0] {
      GESTURE_UP    = 3'd0,
      GESTURE_DOWN  = 3'd1,
      GESTURE_LEFT  = 3'd2,
      GESTURE_RIGHT = 3'd3,
      GESTURE_TAP   = 3'd4
   } gesture_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_SWIPE_MIN_DIST = 2'd0,
      CSR_TAP_MAX_DIST   = 2'd1,
      CSR_TAP_MAX_TIME   = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   localparam int SAMPLE_W   = 16;
   localparam int DIST_W     = 15;
   localparam int TAP_TIME_W = 16;
   localparam int CSR_DATA_W = 16;
   // Magnitudes of coordinates up to 16 bits and 15-bit thresholds compare here.
   localparam int DIST_CMP_W = 16;

   localparam logic [DIST_W-1:0]     SWIPE_MIN_DIST_RESET = 15'd30;
   localparam logic [DIST_W-1:0]     TAP_MAX_DIST_RESET   = 15'd12;
   localparam logic [TAP_TIME_W-1:0] TAP_MAX_TIME_RESET   = 16'd300;

endpackage

// ----- hw/rtl/touch_swipe_tap_classifier_unit.sv -----
// Touch stroke classifier: turns touch controller events into swipe and tap gestures.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_type, req_sample_value
//   rsp      out        rsp_valid/rsp_ready  rsp_gesture_code
//   csr      in         csr_we (no wait)     csr_index, csr_wdata
//
// Every word passes through the input register and, if it is a release that
// classifies as a gesture, goes on into the result register; one word is accepted
// per cycle as long as results are taken.
// Reset is synchronous and active high; it clears the stroke state and loads the
// default thresholds.
// A release that yields a gesture waits in the input register only while the result
// register still holds a gesture that has not been taken; all other words drain freely.
`include "touch_swipe_tap_classifier_unit_macros.svh"

module touch_swipe_tap_classifier_unit #(
   parameter int COORD_BITS = 16,
   parameter int TIMER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic signed [tstc_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_gesture_code,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [tstc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DistW = tstc_pkg::DIST_CMP_W;
   localparam int TimeW = (TIMER_BITS > tstc_pkg::TAP_TIME_W) ? TIMER_BITS
                                                              : tstc_pkg::TAP_TIME_W;

   // Configuration registers.
   logic [tstc_pkg::DIST_W-1:0]     swipe_min_dist_ff;
   logic [tstc_pkg::DIST_W-1:0]     tap_max_dist_ff;
   logic [tstc_pkg::TAP_TIME_W-1:0] tap_max_time_ff;

   // Input register.
   logic                              s1_valid_ff, s1_valid_in;
   tstc_pkg::req_kind_type            s1_kind_ff;
   logic [tstc_pkg::SAMPLE_W-1:0]     s1_value_ff;

   // Stroke state.
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in;
   logic [COORD_BITS-1:0] start_y_ff, start_y_in;
   logic [TIMER_BITS-1:0] press_elapsed_ff, press_elapsed_in;
   logic                  touching_ff, touching_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   tstc_pkg::gesture_type rsp_code_ff;

   // Classification of the stroke that ends now.
   logic [COORD_BITS-1:0] delta_x, delta_y, mag_x, mag_y;
   logic [DistW-1:0]      mag_x_cmp, mag_y_cmp, swipe_cmp, tap_dist_cmp;
   logic [TimeW-1:0]      elapsed_cmp, tap_time_cmp;
   logic                  x_positive, y_positive;
   logic                  gesture_hit;
   tstc_pkg::gesture_type gesture_code;

   logic s1_press, s1_release, s1_emit, s1_advance, out_free;

   // Deltas wrap in the coordinate width; the magnitude of the most negative delta
   // reads as its true value because it is taken as unsigned.
   assign delta_x    = cur_x_ff - start_x_ff;
   assign delta_y    = cur_y_ff - start_y_ff;
   assign mag_x      = delta_x[COORD_BITS-1] ? (~delta_x + COORD_BITS'(1)) : delta_x;
   assign mag_y      = delta_y[COORD_BITS-1] ? (~delta_y + COORD_BITS'(1)) : delta_y;
   assign x_positive = !delta_x[COORD_BITS-1] && (delta_x != '0);
   assign y_positive = !delta_y[COORD_BITS-1] && (delta_y != '0);

   assign mag_x_cmp    = DistW'(mag_x);
   assign mag_y_cmp    = DistW'(mag_y);
   assign swipe_cmp    = DistW'(swipe_min_dist_ff);
   assign tap_dist_cmp = DistW'(tap_max_dist_ff);
   assign elapsed_cmp  = TimeW'(press_elapsed_ff);
   assign tap_time_cmp = TimeW'(tap_max_time_ff);

   // Horizontal swipes win when they dominate; vertical swipes come next; a small
   // and short stroke is a tap; anything else yields no gesture.
   always_comb begin
      gesture_hit  = 1'b1;
      gesture_code = tstc_pkg::GESTURE_TAP;
      if ((mag_x_cmp > mag_y_cmp) && (mag_x_cmp > swipe_cmp)) begin
         gesture_code = x_positive ? tstc_pkg::GESTURE_RIGHT : tstc_pkg::GESTURE_LEFT;
      end else if (mag_y_cmp > swipe_cmp) begin
         gesture_code = y_positive ? tstc_pkg::GESTURE_DOWN : tstc_pkg::GESTURE_UP;
      end else if ((mag_x_cmp <= tap_dist_cmp) && (mag_y_cmp <= tap_dist_cmp) &&
                   (elapsed_cmp <= tap_time_cmp)) begin
         gesture_code = tstc_pkg::GESTURE_TAP;
      end else begin
         gesture_hit = 1'b0;
      end
   end

   // A button word with a nonzero value is a press, with zero a release.
   assign s1_press   = (s1_kind_ff == tstc_pkg::REQ_BUTTON) && (s1_value_ff != '0);
   assign s1_release = (s1_kind_ff == tstc_pkg::REQ_BUTTON) && (s1_value_ff == '0);
   assign s1_emit    = s1_valid_ff && s1_release && touching_ff && gesture_hit;

   // Only a word that produces a gesture needs room in the result register.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!s1_emit || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   end

   // The stroke state commits when the word leaves the input register.
   always_comb begin
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      press_elapsed_in = press_elapsed_ff;
      touching_in      = touching_ff;
      if (s1_advance) begin
         case (s1_kind_ff)
            tstc_pkg::REQ_X_SAMPLE: begin
               cur_x_in = s1_value_ff[COORD_BITS-1:0];
            end
            tstc_pkg::REQ_Y_SAMPLE: begin
               cur_y_in = s1_value_ff[COORD_BITS-1:0];
            end
            tstc_pkg::REQ_TICK: begin
               // The timer saturates and keeps counting whether touching or not.
               if (press_elapsed_ff != '1) begin
                  press_elapsed_in = press_elapsed_ff + TIMER_BITS'(1);
               end
            end
            tstc_pkg::REQ_BUTTON: begin
               if (s1_press) begin
                  touching_in      = 1'b1;
                  start_x_in       = cur_x_ff;
                  start_y_in       = cur_y_ff;
                  press_elapsed_in = '0;
               end else begin
                  touching_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (s1_advance && s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state, stroke state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         start_x_ff        <= '0;
         start_y_ff        <= '0;
         press_elapsed_ff  <= '0;
         touching_ff       <= 1'b0;
         swipe_min_dist_ff <= tstc_pkg::SWIPE_MIN_DIST_RESET;
         tap_max_dist_ff   <= tstc_pkg::TAP_MAX_DIST_RESET;
         tap_max_time_ff   <= tstc_pkg::TAP_MAX_TIME_RESET;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         cur_x_ff         <= cur_x_in;
         cur_y_ff         <= cur_y_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         press_elapsed_ff <= press_elapsed_in;
         touching_ff      <= touching_in;
         if (csr_we) begin
            case (tstc_pkg::csr_index_type'(csr_index))
               tstc_pkg::CSR_SWIPE_MIN_DIST: begin
                  swipe_min_dist_ff <= csr_wdata[tstc_pkg::DIST_W-1:0];
               end
               tstc_pkg::CSR_TAP_MAX_DIST: begin
                  tap_max_dist_ff <= csr_wdata[tstc_pkg::DIST_W-1:0];
               end
               tstc_pkg::CSR_TAP_MAX_TIME: begin
                  tap_max_time_ff <= csr_wdata[tstc_pkg::TAP_TIME_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_kind_ff  <= tstc_pkg::req_kind_type'(req_type);
         s1_value_ff <= req_sample_value;
      end
      if (s1_advance && s1_emit) begin
         rsp_code_ff <= gesture_code;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gesture_code = rsp_code_ff;

   `TSTC_ASSERT_NEXT(a_emit_loads_result, clock, reset, s1_advance && s1_emit,
      rsp_valid_ff, "gesture did not reach the result register")

   `TSTC_ASSERT_IMPLY(a_emit_needs_touch, clock, reset, s1_emit,
      touching_ff && s1_release, "gesture raised outside a release while touching")

   `TSTC_ASSERT_NEXT(a_press_clears_timer, clock, reset, s1_advance && s1_press,
      touching_ff && (press_elapsed_ff == '0), "press did not restart the stroke")

   `TSTC_ASSERT_NEXT(a_release_ends_touch, clock, reset, s1_advance && s1_release,
      !touching_ff, "release left the stroke open")

   `TSTC_ASSERT_IMPLY(a_stall_only_on_full, clock, reset, !req_ready,
      s1_valid_ff && s1_emit && rsp_valid_ff && !rsp_ready,
      "input stalled without a blocked gesture")

endmodule
